// File: hdl/rlms_pkg.sv
// ----------------------------------------------------------------------------
// rlms_pkg - relay line measure sequencer shared definitions
// Register indexes, reset values, field widths and the fixed-point constants
// used to turn raw ADC codes into millivolts.
// ----------------------------------------------------------------------------
package rlms_pkg;

    // Field widths
    localparam int RAW_W    = 12;
    localparam int DELAY_W  = 16;
    localparam int SCALE_W  = 15;
    localparam int MV_W     = 13;
    localparam int SUM_W    = 20;
    localparam int TAKEN_W  = 7;
    localparam int RELAY_W  = 4;
    localparam int PHASE_W  = 2;
    localparam int PROD_W   = RAW_W + SCALE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default averaging depth (log2 of samples per phase)
    localparam int SAMPLES_LOG2_DEFAULT = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELAY_ON_DELAY  = 2'd0,
        REG_MEASURE_PERIOD  = 2'd1,
        REG_SCALE_PER_10000 = 2'd2
    } cfg_index_t;

    // Configuration reset values
    localparam logic [DELAY_W-1:0] RELAY_ON_DELAY_RST  = 16'd5;
    localparam logic [DELAY_W-1:0] MEASURE_PERIOD_RST  = 16'd50;
    localparam logic [SCALE_W-1:0] SCALE_RST           = 15'd8068;

    // Divide by 10000 through a reciprocal: q = (p * RECIP_M) >> RECIP_SHIFT,
    // exact for every p below 2^PROD_W.
    localparam int RECIP_SHIFT = 41;
    localparam int RECIP_M_W   = 28;
    localparam logic [RECIP_M_W-1:0] RECIP_M = 28'd219902326;
    localparam int QUOT_W      = 14;

    localparam logic [MV_W-1:0] MV_MAX = '1;

endpackage

// File: hdl/relay_line_measure_sequencer.sv
// ----------------------------------------------------------------------------
// relay_line_measure_sequencer - four-phase relay line measurement
// Steps through the line1/att1/line2/att2 phases one tick at a time, drives
// the phase relays and stores the averaged millivolt reading of each phase.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Transfer carries
// ---------+-----+-----------------------------------------------------------
// s_axis   | in  | one tick with its raw ADC sample
// m_axis   | out | relay state, phase and the measurement update of the tick
// cfg      | in  | register index and write data
//
// One tick is taken every cycle while m_tready does not hold the pipeline; its
// result reaches m_tdata through three register stages (scale multiply,
// reciprocal divide, state update with result register).
// The whole pipeline advances together and holds while a result waits on
// m_tready.
// Reset clears the phase state, the stored readings and all relays.
// cfg_ready is always high.
//
module relay_line_measure_sequencer #(
    parameter int SAMPLES_LOG2 = rlms_pkg::SAMPLES_LOG2_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] raw_sample
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] relay_drive, [5:4] phase_now,
                                   // [7:6] updated_slot, [20:8] new_millivolts,
                                   // [33:21] old_millivolts, zero above
    output logic        m_tuser,   // [0] update_done
    // Configuration write
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rlms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [rlms_pkg::TAKEN_W-1:0] SAMPLES_N =
        rlms_pkg::TAKEN_W'(1 << SAMPLES_LOG2);

    // Configuration registers
    logic [rlms_pkg::DELAY_W-1:0] delay_reg;
    logic [rlms_pkg::DELAY_W-1:0] period_reg;
    logic [rlms_pkg::SCALE_W-1:0] scale_reg;

    // Pipeline
    logic                          adv;
    logic                          v1_reg;
    logic [rlms_pkg::PROD_W-1:0]   prod_reg;
    logic                          v2_reg;
    logic [rlms_pkg::MV_W-1:0]     mv_reg;

    // Sequencer state
    logic [rlms_pkg::DELAY_W-1:0]  tick_reg,  tick_next;
    logic [rlms_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [rlms_pkg::SUM_W-1:0]    sum_reg,   sum_next;
    logic [rlms_pkg::TAKEN_W-1:0]  taken_reg, taken_next;
    logic [rlms_pkg::RELAY_W-1:0]  relay_reg, relay_next;
    logic [rlms_pkg::MV_W-1:0]     latest_reg [4];

    // Result register
    logic                          out_valid_reg;
    logic [rlms_pkg::RELAY_W-1:0]  out_relay_reg;
    logic [rlms_pkg::PHASE_W-1:0]  out_phase_reg;
    logic                          out_done_reg,  done_next;
    logic [rlms_pkg::PHASE_W-1:0]  out_slot_reg,  slot_next;
    logic [rlms_pkg::MV_W-1:0]     out_new_reg,   new_next;
    logic [rlms_pkg::MV_W-1:0]     out_old_reg,   old_next;

    // Divide stage wires
    logic [rlms_pkg::PROD_W+rlms_pkg::RECIP_M_W-1:0] quot_wide;
    logic [rlms_pkg::QUOT_W-1:0]   quot;
    logic [rlms_pkg::MV_W-1:0]     mv_sat;

    // Update stage wires
    logic [rlms_pkg::RELAY_W-1:0]  phase_bit;
    logic [rlms_pkg::SUM_W-1:0]    sum_add;
    logic [rlms_pkg::TAKEN_W-1:0]  taken_add;

    // Whole pipeline moves when the result register is free or draining
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= rlms_pkg::RELAY_ON_DELAY_RST;
            period_reg <= rlms_pkg::MEASURE_PERIOD_RST;
            scale_reg  <= rlms_pkg::SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rlms_pkg::REG_RELAY_ON_DELAY:  delay_reg  <= cfg_data;
                rlms_pkg::REG_MEASURE_PERIOD:  period_reg <= cfg_data;
                rlms_pkg::REG_SCALE_PER_10000: scale_reg  <= cfg_data[rlms_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Reciprocal divide by 10000 with saturation
    assign quot_wide = (rlms_pkg::PROD_W+rlms_pkg::RECIP_M_W)'(prod_reg)
                     * (rlms_pkg::PROD_W+rlms_pkg::RECIP_M_W)'(rlms_pkg::RECIP_M);
    assign quot      = quot_wide[rlms_pkg::RECIP_SHIFT +: rlms_pkg::QUOT_W];
    assign mv_sat    = (quot > rlms_pkg::QUOT_W'(rlms_pkg::MV_MAX))
                     ? rlms_pkg::MV_MAX : quot[rlms_pkg::MV_W-1:0];

    // Per-tick phase update
    always_comb
    begin
        phase_bit  = rlms_pkg::RELAY_W'(1) << phase_reg;
        tick_next  = tick_reg + 1'b1;
        phase_next = phase_reg;
        sum_next   = sum_reg;
        taken_next = taken_reg;
        relay_next = relay_reg;
        done_next  = 1'b0;
        slot_next  = '0;
        new_next   = '0;
        old_next   = '0;
        sum_add    = sum_reg + rlms_pkg::SUM_W'(mv_reg);
        taken_add  = taken_reg + 1'b1;

        if (tick_next == delay_reg)
        begin
            relay_next = relay_next | phase_bit;
        end

        if (tick_next >= period_reg)
        begin
            sum_next   = sum_add;
            taken_next = taken_add;
            if (taken_add == SAMPLES_N)
            begin
                new_next   = rlms_pkg::MV_W'(sum_add >> SAMPLES_LOG2);
                old_next   = latest_reg[phase_reg];
                relay_next = relay_next & ~phase_bit;
                tick_next  = '0;
                sum_next   = '0;
                taken_next = '0;
                phase_next = phase_reg + 1'b1;
                done_next  = 1'b1;
                slot_next  = phase_reg;
            end
        end
    end

    // Pipeline valids and sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
            phase_reg     <= '0;
            sum_reg       <= '0;
            taken_reg     <= '0;
            relay_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                latest_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
            if (v2_reg)
            begin
                tick_reg  <= tick_next;
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                taken_reg <= taken_next;
                relay_reg <= relay_next;
                if (done_next)
                begin
                    latest_reg[phase_reg] <= new_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg      <= rlms_pkg::PROD_W'(s_tdata[rlms_pkg::RAW_W-1:0])
                           * rlms_pkg::PROD_W'(scale_reg);
            mv_reg        <= mv_sat;
            out_relay_reg <= relay_next;
            out_phase_reg <= phase_next;
            out_done_reg  <= done_next;
            out_slot_reg  <= slot_next;
            out_new_reg   <= new_next;
            out_old_reg   <= old_next;
        end
    end

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_done_reg;
    assign m_tdata  = {6'd0, out_old_reg, out_new_reg, out_slot_reg,
                       out_phase_reg, out_relay_reg};

endmodule
